@@ sv/srt_pkg.sv @@
package srt_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COURSE_W = 8;
  localparam int unsigned GRADE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [GRADE_W-1:0]  grade_bits;
    logic [COURSE_W-1:0] course;
    logic [KEY_W-1:0]    key;
  } record_t;

  // Outcome of comparing a stored key against the request key.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

@@ sv/srt_cmp.sv @@
module srt_cmp import srt_pkg::*; (
  input  logic signed [KEY_W-1:0] stored_key_i,
  input  logic signed [KEY_W-1:0] req_key_i,
  output cmp_res_t                res_o
);

  assign res_o.eq = (stored_key_i == req_key_i);
  assign res_o.gt = (stored_key_i > req_key_i);

endmodule

@@ sv/sorted_record_table_core.sv @@
// Sorted record table. Keeps up to DEPTH records (key, course, grade bits)
// in ascending signed key order in a single-port style memory.
// Requests enter on the s_axis channel: tuser carries the opcode (clear,
// insert, delete, list) and tdata the record. One request is worked on at a
// time; s_axis_tready is high only while the sequencer is idle.
// Results leave on the m_axis channel through an output register, tlast
// marking the final result of a request. Clear, insert and delete give one
// result; list gives one result per stored record, or one empty result.
// One shared key comparator and the memory's registered read port set the
// pace. A scan reads and then compares each entry inspected, and each
// shifted entry is read and then written back; the scan and the shift
// together cover at most DEPTH entries. List reads each record and then
// offers it to the output register. Clear, insert into a full table and
// delete from an empty table go straight to the emit step. A stalled
// receiver holds the sequencer in its emit or list output step; a new request
// can be accepted while the last result still waits in the output register.
// Reset empties the table (count zero) and drops any pending result; the
// record memory itself is not cleared and needs no clearing pass.
module sorted_record_table_core import srt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] key, [39:32] course, [71:40] grade_bits
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] out_key, [39:32] out_course, [71:40] out_grade_bits,
  // [76:72] count, [79:77] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] status, [3] entry_valid
  output logic [3:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_SHIFT,
    S_INS_WR,
    S_DEL_SHIFT,
    S_DEL_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  record_t             req_q, req_d;
  status_e             status_q, status_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    pos_q, pos_d;

  logic                out_valid_q, out_valid_d;
  record_t             out_rec_q, out_rec_d;
  status_e             out_status_q, out_status_d;
  logic                out_entry_q, out_entry_d;
  logic                out_last_q, out_last_d;
  logic [CNT_W-1:0]    out_cnt_q, out_cnt_d;

  record_t             mem [DEPTH];
  record_t             rd_q;
  logic                rd_en;
  logic [CNT_W-1:0]    rd_addr;
  logic                wr_en;
  logic [CNT_W-1:0]    wr_addr;
  record_t             wr_data;

  cmp_res_t            cmp;
  logic                slot_free;
  logic [CNT_W-1:0]    ptr_inc;
  logic [CNT_W-1:0]    ptr_dec;
  logic [COUNT_W+CNT_W-1:0] cnt_wide;

  srt_cmp u_cmp (
    .stored_key_i (rd_q.key),
    .req_key_i    (req_q.key),
    .res_o        (cmp)
  );

  assign slot_free = !out_valid_q || m_axis_tready;
  assign ptr_inc   = ptr_q + CNT_W'(1);
  assign ptr_dec   = ptr_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_d        = req_q;
    status_d     = status_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_rec_d    = out_rec_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    out_cnt_d    = out_cnt_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_data      = rd_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = op_e'(s_axis_tuser);
          req_d    = record_t'(s_axis_tdata);
          ptr_d    = '0;
          status_d = ST_OK;
          case (op_e'(s_axis_tuser))
            OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_EMIT;
            end
            OP_INSERT: begin
              if (cnt_q >= CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_EMIT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_DELETE, OP_LIST: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_EMIT;
              end else if (op_e'(s_axis_tuser) == OP_LIST) begin
                state_d = S_LIST_RD;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            default: state_d = S_EMIT;
          endcase
        end
      end

      S_SCAN_RD: begin
        if (ptr_q == cnt_q) begin
          // Every stored key is smaller than the request key.
          if (op_q == OP_INSERT) begin
            pos_d   = cnt_q;
            ptr_d   = cnt_q;
            state_d = S_INS_SHIFT;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_EMIT;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        // The table is sorted, so the first key not below the request
        // key decides both the match and the insert position.
        if (cmp.eq) begin
          if (op_q == OP_INSERT) begin
            status_d = ST_DUPLICATE;
            state_d  = S_EMIT;
          end else begin
            state_d = S_DEL_SHIFT;
          end
        end else if (cmp.gt) begin
          if (op_q == OP_INSERT) begin
            pos_d   = ptr_q;
            ptr_d   = cnt_q;
            state_d = S_INS_SHIFT;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_EMIT;
          end
        end else begin
          ptr_d   = ptr_inc;
          state_d = S_SCAN_RD;
        end
      end

      S_INS_SHIFT: begin
        if (ptr_q == pos_q) begin
          wr_en   = 1'b1;
          wr_data = req_q;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec;
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        wr_en   = 1'b1;
        ptr_d   = ptr_dec;
        state_d = S_INS_SHIFT;
      end

      S_DEL_SHIFT: begin
        if (ptr_inc == cnt_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc;
          state_d = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        wr_en   = 1'b1;
        ptr_d   = ptr_inc;
        state_d = S_DEL_SHIFT;
      end

      S_LIST_RD: begin
        rd_en   = 1'b1;
        state_d = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_rec_d    = rd_q;
          out_status_d = ST_OK;
          out_entry_d  = 1'b1;
          out_last_d   = (ptr_inc == cnt_q);
          out_cnt_d    = cnt_q;
          if (ptr_inc == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = S_LIST_RD;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_rec_d    = '0;
          out_status_d = status_q;
          out_entry_d  = 1'b0;
          out_last_d   = 1'b1;
          out_cnt_d    = cnt_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_CLEAR;
      req_q        <= '0;
      status_q     <= ST_OK;
      cnt_q        <= '0;
      ptr_q        <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      out_rec_q    <= '0;
      out_status_q <= ST_OK;
      out_entry_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      req_q        <= req_d;
      status_q     <= status_d;
      cnt_q        <= cnt_d;
      ptr_q        <= ptr_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
      out_rec_q    <= out_rec_d;
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_last_q   <= out_last_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  // The count field keeps only its low bits when the table is deep.
  assign cnt_wide = {{COUNT_W{1'b0}}, out_cnt_q};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, cnt_wide[COUNT_W-1:0], out_rec_q};
  assign m_axis_tuser  = {out_entry_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ dv/sorted_record_table_core_test.sv @@
module sorted_record_table_core_test;
  import srt_pkg::*;

  typedef struct {
    status_e            status;
    logic               entry_valid;
    logic [KEY_W-1:0]   key;
    logic [COURSE_W-1:0] course;
    logic [GRADE_W-1:0] grade;
    logic               last;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  // Mirror of the sorted table; every accepted request is applied here and
  // the results it must cause are queued in arrival order.
  class table_scoreboard;
    record_t       rows[DEPTH];
    int unsigned   fill;
    table_result_t due_results[$];
    int unsigned   fail_count;

    function void report(string what);
      $display("ERROR at %0t: %s", $time, what);
      fail_count++;
    endfunction

    function void push(status_e st, logic valid, record_t rec, logic lst);
      table_result_t r;
      r.status      = st;
      r.entry_valid = valid;
      r.key         = rec.key;
      r.course      = rec.course;
      r.grade       = rec.grade_bits;
      r.last        = lst;
      r.count       = COUNT_W'(fill);
      due_results.push_back(r);
    endfunction

    function logic [KEY_W-1:0] stored_key();
      if (fill == 0) return $urandom;
      return rows[$urandom_range(0, fill - 1)].key;
    endfunction

    function void apply_request(op_e op, record_t rec);
      int unsigned pos;
      bit          hit;
      hit = 0;
      pos = fill;
      case (op)
        OP_CLEAR: begin
          fill = 0;
          push(ST_OK, 1'b0, '0, 1'b1);
        end
        OP_INSERT: begin
          // The full check wins over the duplicate check.
          if (fill >= DEPTH) begin
            push(ST_FULL, 1'b0, '0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) if (rows[i].key == rec.key) hit = 1;
            if (hit) begin
              push(ST_DUPLICATE, 1'b0, '0, 1'b1);
            end else begin
              for (int i = fill - 1; i >= 0; i--)
                if ($signed(rec.key) < $signed(rows[i].key)) pos = i;
              for (int i = fill; i > pos; i--) rows[i] = rows[i-1];
              rows[pos] = rec;
              fill++;
              push(ST_OK, 1'b0, '0, 1'b1);
            end
          end
        end
        OP_DELETE: begin
          if (fill == 0) begin
            push(ST_EMPTY, 1'b0, '0, 1'b1);
          end else begin
            for (int i = fill - 1; i >= 0; i--)
              if (rows[i].key == rec.key) begin
                hit = 1;
                pos = i;
              end
            if (!hit) begin
              push(ST_NOT_FOUND, 1'b0, '0, 1'b1);
            end else begin
              for (int i = pos; i + 1 < fill; i++) rows[i] = rows[i+1];
              fill--;
              push(ST_OK, 1'b0, '0, 1'b1);
            end
          end
        end
        default: begin
          if (fill == 0) push(ST_EMPTY, 1'b0, '0, 1'b1);
          for (int i = 0; i < fill; i++) push(ST_OK, 1'b1, rows[i], i + 1 == fill);
        end
      endcase
    endfunction

    function void compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s is %0h, should be %0h", name, got, want));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [3:0] user,
                               logic lst);
      table_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %0h arrived with nothing outstanding", data));
        return;
      end
      want = due_results.pop_front();
      compare("status", 32'(user[2:0]), 32'(want.status));
      compare("entry_valid", 32'(user[3]), 32'(want.entry_valid));
      compare("key", data[31:0], want.key);
      compare("course", 32'(data[39:32]), 32'(want.course));
      compare("grade", data[71:40], want.grade);
      compare("count", 32'(data[76:72]), 32'(want.count));
      compare("pad bits", 32'(data[79:77]), 32'd0);
      compare("last", 32'(lst), 32'(want.last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_axis_tready;
  record_t               s_data;
  logic [1:0]            s_op;
  logic                  m_axis_tvalid;
  logic                  m_ready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [3:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  bit                    calm;

  table_scoreboard sb = new;

  sorted_record_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none during calm stretches.
  function int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Keys mostly come from a narrow band around zero so that duplicates and
  // delete hits are common; the rest span the whole signed range.
  function logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if ($urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, 40);
      return k - 32'd20;
    end
    return $urandom;
  endfunction

  initial begin
    int stall;
    m_ready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic send_request(op_e op, record_t rec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= rec;
    s_op    <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_request(op, rec);
  endtask

  task automatic issue(op_e op, logic [KEY_W-1:0] key);
    logic [COURSE_W-1:0] course;
    logic [GRADE_W-1:0]  grade;
    course = $urandom;
    grade  = $urandom;
    send_request(op, {grade, course, key});
  endtask

  initial begin
    int r;
    op_e op;
    logic [KEY_W-1:0] key;
    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    s_op    = OP_CLEAR;
    calm    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, then the key extremes, minus one and zero.
    issue(OP_LIST, 32'd0);
    issue(OP_DELETE, 32'd7);
    send_request(OP_INSERT, {32'hFFFF_FFFF, 8'hFF, 32'h7FFF_FFFF});
    send_request(OP_INSERT, {32'h0000_0000, 8'h00, 32'h8000_0000});
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'd0);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_DELETE, 32'd5);
    issue(OP_DELETE, 32'h8000_0000);
    issue(OP_DELETE, 32'h7FFF_FFFF);
    // Fill up, then a fresh key and a present key against the full table.
    for (int i = 0; i < DEPTH - 2; i++) issue(OP_INSERT, $urandom);
    issue(OP_INSERT, 32'd12345);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_LIST, 32'd0);
    issue(OP_CLEAR, $urandom);

    for (int n = 0; n < 300; n++) begin
      if (n == 150) begin
        // Let the block drain completely before going on.
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk_i);
      end
      calm = (n >= 200 && n < 240);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op  = OP_CLEAR;
        key = $urandom;
      end else if (r < 50) begin
        op  = OP_INSERT;
        key = ($urandom_range(0, 4) == 0) ? sb.stored_key() : pick_key();
      end else if (r < 82) begin
        op  = OP_DELETE;
        key = ($urandom_range(0, 3) != 0) ? sb.stored_key() : pick_key();
      end else begin
        op  = OP_LIST;
        key = $urandom;
      end
      issue(op, key);
    end
    s_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
